// File: design/tcw_pkg.sv
// shared constants for the text console writer
package tcw_pkg;

    localparam int CELL_W = 16;

    localparam logic [7:0] BLANK_CHAR   = 8'h20;
    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

    // blank cell with the reset colors (fg 7, bg 0)
    localparam logic [CELL_W-1:0] RESET_FILL = 16'h0720;

    localparam logic [3:0] RESET_FG = 4'd7;
    localparam logic [3:0] RESET_BG = 4'd0;

    // operation codes
    localparam logic [1:0] FUNC_PUT   = 2'd0;
    localparam logic [1:0] FUNC_CLEAR = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_FG = 2'd0;
    localparam logic [1:0] CFG_BG = 2'd1;

endpackage

// File: design/tcw_cell_ram.sv
// screen cell memory, one write port and one registered read port
module tcw_cell_ram
    import tcw_pkg::*;
#(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [CELL_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [CELL_W-1:0] o_rdata
);

    logic [CELL_W-1:0] r_mem [DEPTH];
    logic [CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/tcw_addr_alu.sv
// shared address adder with end-of-range compare
module tcw_addr_alu #(
    parameter int AW = 11
) (
    input  logic [AW-1:0] i_a,
    input  logic [AW-1:0] i_b,
    input  logic [AW-1:0] i_lim,
    output logic [AW-1:0] o_sum,
    output logic          o_at_lim
);

    assign o_sum    = i_a + i_b;
    assign o_at_lim = (i_a == i_lim);

endmodule

// File: design/text_console_writer_unit.sv
// text console writer top level: sequencer, cursor, colors and cell memory
// usage
//   commands enter on start/i_func/i_char_code/i_cell_index and are taken
//   at a clock edge where start is high and busy is low. every command gives
//   exactly one result: o_done pulses for one cycle with o_cursor_pos (linear
//   cursor after the command) and o_cell_data (cell for a read, else zero).
//   results cannot be held off; o_done always comes with busy already low,
//   so a new command may be issued in the same cycle as the result.
//   colors are written on the cfg channel (i_cfg_valid/o_cfg_ready,
//   always ready); the user writes them only between commands, unchecked by
//   the block; they apply to later writes.
// command steps after acceptance
//   put character: S_PUT writes the cell, then S_RESP; a newline, or a put
//   at the last column, goes through S_NEXT; read cell: S_RD, S_RD2, S_RESP;
//   unused code: S_RESP; clear: all ROWS*COLUMNS cells, one written per cycle
//   scroll (wrap or newline on the last row): each cell copy is a read then a
//   write through the single memory port pair, steered by one shared adder
// reset
//   synchronous active-low reset homes the cursor, restores the colors and
//   starts a blanking pass over all ROWS*COLUMNS cells; busy stays high
//   during the pass and color writes are still taken
module text_console_writer_unit
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_char_code,
    input  logic [10:0] i_cell_index,
    // result channel
    output logic        o_done,
    output logic [10:0] o_cursor_pos,
    output logic [15:0] o_cell_data,
    // color configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data
);

    localparam int CELLS    = ROWS * COLUMNS;
    localparam int AW       = $clog2(CELLS);
    localparam int RW       = $clog2(ROWS);
    localparam int CLW      = $clog2(COLUMNS);
    localparam int IW       = 11;
    // one spare bit so the cell count itself always fits for the range check
    localparam int CW       = ((AW > IW) ? AW : IW) + 1;
    localparam int SCR_LAST = (ROWS - 1) * COLUMNS - 1;

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PUT    = 4'd1;
    localparam logic [3:0] S_NEXT   = 4'd2;
    localparam logic [3:0] S_SCR_RD = 4'd3;
    localparam logic [3:0] S_SCR_WR = 4'd4;
    localparam logic [3:0] S_FILL   = 4'd5;
    localparam logic [3:0] S_RD     = 4'd6;
    localparam logic [3:0] S_RD2    = 4'd7;
    localparam logic [3:0] S_RESP   = 4'd8;

    logic [3:0]        r_state,    n_state;
    logic [RW-1:0]     r_row,      n_row;
    logic [CLW-1:0]    r_col,      n_col;
    logic [AW-1:0]     r_base,     n_base;     // row * COLUMNS
    logic [AW-1:0]     r_pos,      n_pos;      // base + col
    logic [AW-1:0]     r_addr,     n_addr;     // sweep pointer
    logic [CELL_W-1:0] r_fill,     n_fill;     // blank used by sweeps
    logic              r_quiet,    n_quiet;    // reset pass, no result
    logic [3:0]        r_fg,       n_fg;
    logic [3:0]        r_bg,       n_bg;
    logic [7:0]        r_char,     n_char;
    logic [AW-1:0]     r_idx,      n_idx;
    logic              r_idx_ok,   n_idx_ok;
    logic [CELL_W-1:0] r_data,     n_data;
    logic              r_done,     n_done;
    logic [10:0]       r_out_pos,  n_out_pos;
    logic [15:0]       r_out_data, n_out_data;

    // shared adder controls
    logic [AW-1:0]     alu_a, alu_b, alu_lim, alu_sum;
    logic              alu_at_lim;

    // memory port controls
    logic              mem_we;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [CELL_W-1:0] mem_wdata, mem_rdata;

    logic              accept;
    logic [CW-1:0]     idx_ext;

    assign accept  = start && (r_state == S_IDLE);
    assign idx_ext = CW'(i_cell_index);

    tcw_addr_alu #(
        .AW (AW)
    ) u_alu (
        .i_a      (alu_a),
        .i_b      (alu_b),
        .i_lim    (alu_lim),
        .o_sum    (alu_sum),
        .o_at_lim (alu_at_lim)
    );

    tcw_cell_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // adder operand steering: one add per cycle, picked by state
    always_comb begin
        alu_a   = r_addr;
        alu_b   = AW'(1);
        alu_lim = AW'(CELLS - 1);
        case (r_state)
            S_PUT: begin
                alu_a = r_pos;
            end
            S_NEXT: begin
                alu_a = r_base;
                alu_b = AW'(COLUMNS);
            end
            S_SCR_RD: begin
                alu_b = AW'(COLUMNS);   // source cell one row below
            end
            S_SCR_WR: begin
                alu_lim = AW'(SCR_LAST);
            end
            default: begin
                alu_a = r_addr;
            end
        endcase
    end

    // memory port steering
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = r_fill;
        mem_raddr = r_idx;
        case (r_state)
            S_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos;
                mem_wdata = {r_bg, r_fg, r_char};
            end
            S_SCR_RD: begin
                mem_raddr = alu_sum;
            end
            S_SCR_WR: begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata;
            end
            S_FILL: begin
                mem_we = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_row      = r_row;
        n_col      = r_col;
        n_base     = r_base;
        n_pos      = r_pos;
        n_addr     = r_addr;
        n_fill     = r_fill;
        n_quiet    = r_quiet;
        n_fg       = r_fg;
        n_bg       = r_bg;
        n_char     = r_char;
        n_idx      = r_idx;
        n_idx_ok   = r_idx_ok;
        n_data     = r_data;
        n_done     = 1'b0;
        n_out_pos  = r_out_pos;
        n_out_data = r_out_data;

        // color writes are taken at any time
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FG:  n_fg = i_cfg_data;
                CFG_BG:  n_bg = i_cfg_data;
                default: n_fg = r_fg;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_char   = i_char_code;
                    n_idx    = AW'(i_cell_index);
                    n_idx_ok = (idx_ext < CW'(CELLS));
                    n_data   = '0;
                    n_fill   = {r_bg, r_fg, BLANK_CHAR};
                    case (i_func)
                        FUNC_PUT: begin
                            if (i_char_code == NEWLINE_CHAR) begin
                                n_state = S_NEXT;
                            end else begin
                                n_state = S_PUT;
                            end
                        end
                        FUNC_CLEAR: begin
                            n_row   = '0;
                            n_col   = '0;
                            n_base  = '0;
                            n_pos   = '0;
                            n_addr  = '0;
                            n_state = S_FILL;
                        end
                        FUNC_READ: begin
                            n_state = S_RD;
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_PUT: begin
                // cell is written this cycle; advance or wrap
                if (r_col == CLW'(COLUMNS - 1)) begin
                    n_state = S_NEXT;
                end else begin
                    n_col   = r_col + CLW'(1);
                    n_pos   = alu_sum;
                    n_state = S_RESP;
                end
            end
            S_NEXT: begin
                n_col = '0;
                if (r_row == RW'(ROWS - 1)) begin
                    // bottom row: stay there and scroll
                    n_pos   = r_base;
                    n_addr  = '0;
                    n_state = S_SCR_RD;
                end else begin
                    n_row   = r_row + RW'(1);
                    n_base  = alu_sum;
                    n_pos   = alu_sum;
                    n_state = S_RESP;
                end
            end
            S_SCR_RD: begin
                n_state = S_SCR_WR;
            end
            S_SCR_WR: begin
                n_addr = alu_sum;
                if (alu_at_lim) begin
                    n_state = S_FILL;   // blank the bottom row next
                end else begin
                    n_state = S_SCR_RD;
                end
            end
            S_FILL: begin
                n_addr = alu_sum;
                if (alu_at_lim) begin
                    n_quiet = 1'b0;
                    n_state = r_quiet ? S_IDLE : S_RESP;
                end
            end
            S_RD: begin
                n_state = S_RD2;
            end
            S_RD2: begin
                n_data  = r_idx_ok ? mem_rdata : '0;
                n_state = S_RESP;
            end
            S_RESP: begin
                n_done     = 1'b1;
                n_out_pos  = 11'(r_pos);
                n_out_data = r_data;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_FILL;   // blanking pass after reset
            r_row    <= '0;
            r_col    <= '0;
            r_base   <= '0;
            r_pos    <= '0;
            r_addr   <= '0;
            r_fill   <= RESET_FILL;
            r_quiet  <= 1'b1;
            r_fg     <= RESET_FG;
            r_bg     <= RESET_BG;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_row    <= n_row;
            r_col    <= n_col;
            r_base   <= n_base;
            r_pos    <= n_pos;
            r_addr   <= n_addr;
            r_fill   <= n_fill;
            r_quiet  <= n_quiet;
            r_fg     <= n_fg;
            r_bg     <= n_bg;
            r_done   <= n_done;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_char     <= n_char;
        r_idx      <= n_idx;
        r_idx_ok   <= n_idx_ok;
        r_data     <= n_data;
        r_out_pos  <= n_out_pos;
        r_out_data <= n_out_data;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_done       = r_done;
    assign o_cursor_pos = r_out_pos;
    assign o_cell_data  = r_out_data;
    assign o_cfg_ready  = 1'b1;

    // result strobe only ever comes once the sequencer is back in idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // every accepted command makes the sequencer busy in the following cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command accepted without going busy");

    // cursor column stays on the grid
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_col) < COLUMNS)
        else $error("cursor column out of range");

    a_pos_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (int'(r_pos) == int'(r_base) + int'(r_col)))
        else $error("linear cursor out of step with row and column");

    // reset blanking pass never reports a result
    a_quiet_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_quiet |-> !o_done)
        else $error("result during reset blanking pass");

endmodule
